@@ rtl/pbt_pkg.sv @@
// ----------------------------------------------------------------------------
// pbt_pkg: shared types and constants of the perceptron batch trainer
// Widths of the fixed-point datapath, register codes, state encoding and the
// structs that pass between the controller, the multiply pipe and the memory.
// ----------------------------------------------------------------------------
package pbt_pkg;

	// sample store geometry
	localparam int MAX_SAMPLES = 64;
	localparam int ADDR_W      = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

	// number formats
	localparam int FRAC   = 12;
	localparam int X_W    = 16;
	localparam int W_W    = 32;
	localparam int LR_W   = 12;
	localparam int TOL_W  = 12;
	localparam int EP_W   = 16;
	localparam int PROD_W = W_W + X_W;
	localparam int DOT_W  = PROD_W + 1;
	localparam int LRX_W  = LR_W + 1 + X_W;
	localparam int RND_W  = LRX_W + 1;
	localparam int TERM_W = RND_W - FRAC;

	localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1) <<< (FRAC - 1);

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [LR_W-1:0]         LR_RESET    = LR_W'(410);
	localparam logic signed [W_W-1:0]   THR_RESET   = '0;
	localparam logic [EP_W-1:0]         EPOCH_RESET = EP_W'(1000);
	localparam logic [TOL_W-1:0]        TOL_RESET   = TOL_W'(4);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEARNING_RATE = 2'd0,
		CFG_THRESHOLD     = 2'd1,
		CFG_MAX_EPOCHS    = 2'd2,
		CFG_TOLERANCE     = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLASSIFY,
		ST_EPOCH,
		ST_WALK,
		ST_DRAIN,
		ST_UPDATE,
		ST_CHECK,
		ST_REPORT
	} state_t;

	// one stored training sample
	typedef struct packed {
		logic signed [X_W-1:0] x0;
		logic signed [X_W-1:0] x1;
		logic                  tgt;
	} sample_t;

	// request into the multiply pipe
	typedef struct packed {
		logic valid;
		logic cls;
	} issue_t;

	// what leaves the multiply pipe
	typedef struct packed {
		logic                     valid;
		logic                     cls;
		logic                     pred;
		logic                     mis;
		logic                     pending;
		logic signed [TERM_W-1:0] term0;
		logic signed [TERM_W-1:0] term1;
	} pipe_res_t;

	// result request from the controller to the output register
	typedef struct packed {
		logic            valid;
		logic            train;
		logic            pred;
		logic            status;
		logic [EP_W-1:0] epochs;
	} report_t;

endpackage

@@ rtl/perceptron_batch_trainer_unit.sv @@
// ----------------------------------------------------------------------------
// perceptron_batch_trainer_unit: two-input perceptron with batch training
// Load request: a new one may follow every cycle unless it ends the batch.
// Classify request: the result strobe follows the pipe stages and done register.
// Training: each epoch is bound by the single read port walking one stored
// sample per cycle, then drains the pipe, updates and checks the weights; the
// report follows a settling check, or the epoch state that reaches the limit.
// Reset clears weights, count and settings; stored samples are undefined.
// Results are shown for one cycle on done; the receiver cannot stall.
// ----------------------------------------------------------------------------
module perceptron_batch_trainer_unit import pbt_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   op,
	input  logic signed [X_W-1:0]  sample_x0,
	input  logic signed [X_W-1:0]  sample_x1,
	input  logic                   target_class,
	input  logic                   last_sample,
	input  logic                   cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	output logic                   done,
	output logic                   is_training_report,
	output logic                   predicted_class,
	output logic signed [W_W-1:0]  weight_0,
	output logic signed [W_W-1:0]  weight_1,
	output logic [EP_W-1:0]        epochs_run,
	output logic                   train_status
);

	logic [LR_W-1:0]       lr_q;
	logic signed [W_W-1:0] thr_q;
	logic [EP_W-1:0]       max_ep_q;
	logic [TOL_W-1:0]      tol_q;

	issue_t                issue;
	pipe_res_t             res;
	report_t               report;
	sample_t               wdata, rdata;
	logic                  mem_we;
	logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
	logic signed [W_W-1:0] w0, w1;

	logic                  done_q, train_q, pred_q, status_q;
	logic signed [W_W-1:0] w0_q, w1_q;
	logic [EP_W-1:0]       epochs_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q     <= LR_RESET;
			thr_q    <= THR_RESET;
			max_ep_q <= EPOCH_RESET;
			tol_q    <= TOL_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_LEARNING_RATE: lr_q     <= cfg_wdata[LR_W-1:0];
				CFG_THRESHOLD:     thr_q    <= signed'(cfg_wdata[W_W-1:0]);
				CFG_MAX_EPOCHS:    max_ep_q <= cfg_wdata[EP_W-1:0];
				CFG_TOLERANCE:     tol_q    <= cfg_wdata[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	assign wdata.x0  = sample_x0;
	assign wdata.x1  = sample_x1;
	assign wdata.tgt = target_class;

	pbt_sample_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (wdata),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	pbt_mac_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.pt_x0     (sample_x0),
		.pt_x1     (sample_x1),
		.mem_rdata (rdata),
		.w0        (w0),
		.w1        (w1),
		.lr        (lr_q),
		.thr       (thr_q),
		.res       (res)
	);

	pbt_train_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.op          (op),
		.last_sample (last_sample),
		.max_epochs  (max_ep_q),
		.tol         (tol_q),
		.res         (res),
		.busy        (busy),
		.issue       (issue),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_raddr   (mem_raddr),
		.w0          (w0),
		.w1          (w1),
		.report      (report)
	);

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= report.valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (report.valid) begin
			train_q  <= report.train;
			pred_q   <= report.pred;
			status_q <= report.status;
			epochs_q <= report.epochs;
			w0_q     <= w0;
			w1_q     <= w1;
		end
	end

	assign done               = done_q;
	assign is_training_report = train_q;
	assign predicted_class    = pred_q;
	assign weight_0           = w0_q;
	assign weight_1           = w1_q;
	assign epochs_run         = epochs_q;
	assign train_status       = status_q;

endmodule

@@ rtl/pbt_sample_mem.sv @@
// ----------------------------------------------------------------------------
// pbt_sample_mem: training sample store
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pbt_sample_mem import pbt_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  sample_t           wdata,
	input  logic [ADDR_W-1:0] raddr,
	output sample_t           rdata
);

	sample_t mem_q [MAX_SAMPLES];
	sample_t rd_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_q <= mem_q[raddr];
	end

	assign rdata = rd_q;

endmodule

@@ rtl/pbt_mac_pipe.sv @@
// ----------------------------------------------------------------------------
// pbt_mac_pipe: three-stage dot product and weight-change pipe
// Stage 1 holds the operand (memory read or classify point), stage 2 the
// products, stage 3 the class decision and the rounded change terms.
// ----------------------------------------------------------------------------
module pbt_mac_pipe import pbt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  issue_t                issue,
	input  logic signed [X_W-1:0] pt_x0,
	input  logic signed [X_W-1:0] pt_x1,
	input  sample_t               mem_rdata,
	input  logic signed [W_W-1:0] w0,
	input  logic signed [W_W-1:0] w1,
	input  logic [LR_W-1:0]       lr,
	input  logic signed [W_W-1:0] thr,
	output pipe_res_t             res
);

	logic                     v_s1, cls_s1;
	logic signed [X_W-1:0]    px0_s1, px1_s1;
	logic signed [X_W-1:0]    x0, x1;

	logic                     v_s2, cls_s2, tgt_s2;
	logic signed [PROD_W-1:0] prod0_s2, prod1_s2;
	logic signed [LRX_W-1:0]  lrx0_s2, lrx1_s2;

	logic                     v_s3, cls_s3, pred_s3, mis_s3;
	logic signed [TERM_W-1:0] term0_s3, term1_s3;

	logic signed [LR_W:0]     lr_s;
	logic signed [DOT_W-1:0]  dot, thr_dot;
	logic signed [RND_W-1:0]  pos0, neg0, pos1, neg1;
	logic                     pred;

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			cls_s1 <= 1'b0;
		end else begin
			v_s1   <= issue.valid;
			cls_s1 <= issue.cls;
		end
	end

	// hold the classify point
	always_ff @(posedge clk) begin
		if (issue.valid && issue.cls) begin
			px0_s1 <= pt_x0;
			px1_s1 <= pt_x1;
		end
	end

	assign x0   = cls_s1 ? px0_s1 : mem_rdata.x0;
	assign x1   = cls_s1 ? px1_s1 : mem_rdata.x1;
	assign lr_s = signed'({1'b0, lr});

	// stage 2: products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2   <= 1'b0;
			cls_s2 <= 1'b0;
		end else begin
			v_s2   <= v_s1;
			cls_s2 <= cls_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod0_s2 <= PROD_W'(w0) * PROD_W'(x0);
		prod1_s2 <= PROD_W'(w1) * PROD_W'(x1);
		lrx0_s2  <= LRX_W'(lr_s) * LRX_W'(x0);
		lrx1_s2  <= LRX_W'(lr_s) * LRX_W'(x1);
		tgt_s2   <= mem_rdata.tgt;
	end

	// stage 3: decide class and round the change terms both ways
	assign dot     = DOT_W'(prod0_s2) + DOT_W'(prod1_s2);
	assign thr_dot = {{(DOT_W - W_W - FRAC){thr[W_W-1]}}, thr, {FRAC{1'b0}}};
	assign pred    = (dot >= thr_dot);

	assign pos0 = RND_W'(lrx0_s2) + RND_HALF;
	assign neg0 = RND_HALF - RND_W'(lrx0_s2);
	assign pos1 = RND_W'(lrx1_s2) + RND_HALF;
	assign neg1 = RND_HALF - RND_W'(lrx1_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3   <= 1'b0;
			cls_s3 <= 1'b0;
		end else begin
			v_s3   <= v_s2;
			cls_s3 <= cls_s2;
		end
	end

	always_ff @(posedge clk) begin
		pred_s3  <= pred;
		mis_s3   <= (pred != tgt_s2);
		term0_s3 <= tgt_s2 ? pos0[RND_W-1:FRAC] : neg0[RND_W-1:FRAC];
		term1_s3 <= tgt_s2 ? pos1[RND_W-1:FRAC] : neg1[RND_W-1:FRAC];
	end

	always_comb begin
		res.valid   = v_s3;
		res.cls     = cls_s3;
		res.pred    = pred_s3;
		res.mis     = mis_s3;
		res.pending = v_s1 | v_s2 | v_s3;
		res.term0   = term0_s3;
		res.term1   = term1_s3;
	end

endmodule

@@ rtl/pbt_train_ctrl.sv @@
// ----------------------------------------------------------------------------
// pbt_train_ctrl: request handling and training sequencer
// Owns the sample count, the weights, the change sums and the epoch loop;
// walks the sample store one entry per cycle through the multiply pipe.
// ----------------------------------------------------------------------------
module pbt_train_ctrl import pbt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  op,
	input  logic                  last_sample,
	input  logic [EP_W-1:0]       max_epochs,
	input  logic [TOL_W-1:0]      tol,
	input  pipe_res_t             res,
	output logic                  busy,
	output issue_t                issue,
	output logic                  mem_we,
	output logic [ADDR_W-1:0]     mem_waddr,
	output logic [ADDR_W-1:0]     mem_raddr,
	output logic signed [W_W-1:0] w0,
	output logic signed [W_W-1:0] w1,
	output report_t               report
);

	state_t                state_q, state_d;
	logic [CNT_W-1:0]      count_q, rd_idx_q, rd_next;
	logic [EP_W-1:0]       epoch_q;
	logic                  status_q;
	logic signed [W_W-1:0] w0_q, w1_q, pw0_q, pw1_q, cs0_q, cs1_q;

	logic                  accept, start_train, store_ok, rd_last, limit, settled;
	logic signed [W_W:0]   d0, d1, tol_s;

	function automatic logic signed [W_W-1:0] sat_w(input logic signed [W_W:0] v);
		if (v[W_W] != v[W_W-1]) begin
			return v[W_W] ? {1'b1, {(W_W-1){1'b0}}} : {1'b0, {(W_W-1){1'b1}}};
		end
		return v[W_W-1:0];
	endfunction

	assign accept      = start && (state_q == ST_IDLE);
	assign start_train = accept && !op && last_sample;
	assign store_ok    = count_q < CNT_W'(MAX_SAMPLES);
	assign rd_next     = rd_idx_q + CNT_W'(1);
	assign rd_last     = (rd_next == count_q);
	assign limit       = (epoch_q >= max_epochs);

	// settle test on the weight move of this epoch
	assign d0      = (W_W+1)'(w0_q) - (W_W+1)'(pw0_q);
	assign d1      = (W_W+1)'(w1_q) - (W_W+1)'(pw1_q);
	assign tol_s   = signed'((W_W+1)'(tol));
	assign settled = (d0 <= tol_s) && (d0 >= -tol_s) && (d1 <= tol_s) && (d1 >= -tol_s);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (op) begin
						state_d = ST_CLASSIFY;
					end else if (last_sample) begin
						state_d = ST_EPOCH;
					end
				end
			end
			ST_CLASSIFY: begin
				if (res.valid && res.cls) begin
					state_d = ST_IDLE;
				end
			end
			ST_EPOCH: begin
				if (limit) begin
					state_d = ST_REPORT;
				end else if (count_q == '0) begin
					state_d = ST_DRAIN;
				end else begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (rd_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!res.pending) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: state_d = ST_CHECK;
			ST_CHECK: begin
				state_d = settled ? ST_REPORT : ST_EPOCH;
			end
			ST_REPORT: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy           = (state_q != ST_IDLE);
		issue.valid    = (state_q == ST_WALK) || (accept && op);
		issue.cls      = (state_q != ST_WALK);
		mem_we         = accept && !op && store_ok;
		mem_waddr      = count_q[ADDR_W-1:0];
		mem_raddr      = rd_idx_q[ADDR_W-1:0];
		report.valid   = (state_q == ST_REPORT) ||
		                 ((state_q == ST_CLASSIFY) && res.valid && res.cls);
		report.train   = (state_q == ST_REPORT);
		report.pred    = (state_q == ST_REPORT) ? 1'b0 : res.pred;
		report.status  = (state_q == ST_REPORT) ? status_q : 1'b0;
		report.epochs  = (state_q == ST_REPORT) ? epoch_q : '0;
	end

	// state, counters and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			rd_idx_q <= '0;
			epoch_q  <= '0;
			status_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_REPORT) begin
				count_q <= '0;
			end else if (mem_we) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (state_q == ST_EPOCH) begin
				rd_idx_q <= '0;
			end else if (state_q == ST_WALK) begin
				rd_idx_q <= rd_next;
			end
			if (start_train) begin
				epoch_q <= '0;
			end else if ((state_q == ST_CHECK) && !settled) begin
				epoch_q <= epoch_q + EP_W'(1);
			end
			if ((state_q == ST_EPOCH) && limit) begin
				status_q <= 1'b1;
			end else if ((state_q == ST_CHECK) && settled) begin
				status_q <= 1'b0;
			end
		end
	end

	// weights, previous weights and change sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_q  <= '0;
			w1_q  <= '0;
			pw0_q <= '0;
			pw1_q <= '0;
			cs0_q <= '0;
			cs1_q <= '0;
		end else begin
			if (start_train) begin
				w0_q  <= '0;
				w1_q  <= '0;
				pw0_q <= '0;
				pw1_q <= '0;
			end else if (state_q == ST_UPDATE) begin
				w0_q <= sat_w((W_W+1)'(w0_q) + (W_W+1)'(cs0_q));
				w1_q <= sat_w((W_W+1)'(w1_q) + (W_W+1)'(cs1_q));
			end else if ((state_q == ST_CHECK) && !settled) begin
				pw0_q <= w0_q;
				pw1_q <= w1_q;
			end
			if (state_q == ST_EPOCH) begin
				cs0_q <= '0;
				cs1_q <= '0;
			end else if (res.valid && !res.cls && res.mis) begin
				cs0_q <= sat_w((W_W+1)'(cs0_q) + (W_W+1)'(res.term0));
				cs1_q <= sat_w((W_W+1)'(cs1_q) + (W_W+1)'(res.term1));
			end
		end
	end

	assign w0 = w0_q;
	assign w1 = w1_q;

endmodule

@@ dv/perceptron_batch_trainer_checker.sv @@
// ----------------------------------------------------------------------------
// perceptron_batch_trainer_checker: result scoreboard for the perceptron unit
// Watches the request, register and result ports. Keeps its own batch of
// samples, its own weights and its own registers. Works out each result when
// its request is taken and compares every strobed result, field by field,
// against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
package pbt_tb_pkg;

	typedef enum logic {
		OP_LOAD     = 1'b0,
		OP_CLASSIFY = 1'b1
	} opcode_t;

	typedef enum logic {
		TRAIN_SETTLED = 1'b0,
		TRAIN_CAPPED  = 1'b1
	} train_status_t;

endpackage

module perceptron_batch_trainer_checker import pbt_pkg::*; import pbt_tb_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   busy,
	input  logic                   op,
	input  logic signed [X_W-1:0]  sample_x0,
	input  logic signed [X_W-1:0]  sample_x1,
	input  logic                   target_class,
	input  logic                   last_sample,
	input  logic                   cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   done,
	input  logic                   is_training_report,
	input  logic                   predicted_class,
	input  logic signed [W_W-1:0]  weight_0,
	input  logic signed [W_W-1:0]  weight_1,
	input  logic [EP_W-1:0]        epochs_run,
	input  logic                   train_status,
	output int                     errors,
	output int                     pending,
	output int                     reports,
	output int                     capped,
	output int                     answers
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint W_MAX = 64'sd2147483647;
	localparam longint W_MIN = -64'sd2147483648;

	typedef struct packed {
		logic                  train;
		logic                  pred;
		logic signed [W_W-1:0] w0;
		logic signed [W_W-1:0] w1;
		logic [EP_W-1:0]       epochs;
		logic                  status;
	} outcome_t;

	outcome_t outcome_q[$];

	// registers as last written
	logic [LR_W-1:0]        rate;
	logic signed [W_W-1:0]  thr;
	logic [EP_W-1:0]        epoch_cap;
	logic [TOL_W-1:0]       tol;

	// current batch and weights
	longint      sx0 [MAX_SAMPLES];
	longint      sx1 [MAX_SAMPLES];
	logic        stgt [MAX_SAMPLES];
	int unsigned batch_len;
	longint      wt [2];

	int fail_count, report_count, cap_count, answer_count;

	function automatic longint clamp_w(input longint v);
		if (v > W_MAX) return W_MAX;
		if (v < W_MIN) return W_MIN;
		return v;
	endfunction

	function automatic longint magnitude(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// dot product in Q.24 against the threshold scaled to Q.24
	function automatic logic decide(input longint x0, input longint x1);
		return (wt[0] * x0 + wt[1] * x1) >= longint'(thr) * 64'sd4096;
	endfunction

	// rate * x * direction, rounded half up back to Q.12
	function automatic longint change_term(input longint x, input longint dir);
		return (longint'(rate) * x * dir + 64'sd2048) >>> FRAC;
	endfunction

	// run epochs over the batch until the weights settle or the cap is hit
	function automatic void train_batch(output logic status_out,
			output logic [EP_W-1:0] stop_epoch);
		longint      prev0, prev1, sum0, sum1, dir;
		int unsigned e;
		logic        guess;
		wt[0] = 0;
		wt[1] = 0;
		prev0 = 0;
		prev1 = 0;
		status_out = TRAIN_CAPPED;
		e = 0;
		while (e < epoch_cap) begin
			sum0 = 0;
			sum1 = 0;
			for (int i = 0; i < batch_len; i++) begin
				guess = decide(sx0[i], sx1[i]);
				if (guess != stgt[i]) begin
					dir = stgt[i] ? 64'sd1 : -64'sd1;
					sum0 = clamp_w(sum0 + change_term(sx0[i], dir));
					sum1 = clamp_w(sum1 + change_term(sx1[i], dir));
				end
			end
			wt[0] = clamp_w(wt[0] + sum0);
			wt[1] = clamp_w(wt[1] + sum1);
			if (magnitude(wt[0] - prev0) <= longint'(tol) &&
					magnitude(wt[1] - prev1) <= longint'(tol)) begin
				status_out = TRAIN_SETTLED;
				break;
			end
			prev0 = wt[0];
			prev1 = wt[1];
			e++;
		end
		stop_epoch = e[EP_W-1:0];
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			fail_count++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t        want;
		logic            stop_status;
		logic [EP_W-1:0] stop_epoch;
		if (!arst_n) begin
			rate = 12'd410;
			thr = '0;
			epoch_cap = 16'd1000;
			tol = 12'd4;
			batch_len = 0;
			wt[0] = 0;
			wt[1] = 0;
			outcome_q.delete();
		end else begin
			// compare a strobed result with the oldest prediction
			if (done) begin
				if (outcome_q.size() == 0) begin
					fail_count++;
					$display("%0t ns: result with no request outstanding, report %0b w0 %0d w1 %0d",
						$time, is_training_report, weight_0, weight_1);
				end else begin
					want = outcome_q.pop_front();
					check_field("is_training_report", want.train, is_training_report);
					check_field("predicted_class", want.pred, predicted_class);
					check_field("weight_0", want.w0, weight_0);
					check_field("weight_1", want.w1, weight_1);
					check_field("epochs_run", want.epochs, epochs_run);
					check_field("train_status", want.status, train_status);
					if (want.train) begin
						report_count++;
						if (want.status == TRAIN_CAPPED)
							cap_count++;
					end else begin
						answer_count++;
					end
				end
			end

			// predict the request taken at this edge
			if (start && !busy) begin
				want = '0;
				if (op == OP_LOAD) begin
					// drop the sample once the store is full
					if (batch_len < MAX_SAMPLES) begin
						sx0[batch_len] = longint'(sample_x0);
						sx1[batch_len] = longint'(sample_x1);
						stgt[batch_len] = target_class;
						batch_len++;
					end
					if (last_sample) begin
						train_batch(stop_status, stop_epoch);
						batch_len = 0;
						want.train = 1'b1;
						want.w0 = wt[0][W_W-1:0];
						want.w1 = wt[1][W_W-1:0];
						want.epochs = stop_epoch;
						want.status = stop_status;
						outcome_q = {outcome_q, want};
					end
				end else begin
					want.pred = decide(longint'(sample_x0), longint'(sample_x1));
					want.w0 = wt[0][W_W-1:0];
					want.w1 = wt[1][W_W-1:0];
					outcome_q = {outcome_q, want};
				end
			end

			// track register writes
			if (cfg_wr_en) begin
				case (cfg_idx_t'(cfg_index))
					CFG_LEARNING_RATE: rate = cfg_wdata[LR_W-1:0];
					CFG_THRESHOLD:     thr = cfg_wdata;
					CFG_MAX_EPOCHS:    epoch_cap = cfg_wdata[EP_W-1:0];
					CFG_TOLERANCE:     tol = cfg_wdata[TOL_W-1:0];
					default: ;
				endcase
			end
		end
		errors <= fail_count;
		pending <= outcome_q.size();
		reports <= report_count;
		capped <= cap_count;
		answers <= answer_count;
	end

endmodule

@@ dv/perceptron_batch_trainer_unit_tb.sv @@
// ----------------------------------------------------------------------------
// perceptron_batch_trainer_unit_tb: top of the perceptron trainer testbench
// Drives load and classify requests and register writes into the unit: a
// directed pass over extreme fields and registers, then random phases with
// random settings, batch sizes up to past the store size, random labels and
// random idle gaps. The checker beside the unit scores every result.
// ----------------------------------------------------------------------------
module perceptron_batch_trainer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pbt_pkg::*;
	import pbt_tb_pkg::*;

	localparam int REQUEST_GOAL  = 1000;
	localparam int RANDOM_PHASES = 12;
	localparam int TAIL_CYCLES   = 12;

	localparam logic signed [X_W-1:0] X_MIN = 16'sh8000;
	localparam logic signed [X_W-1:0] X_MAX = 16'sh7fff;
	localparam logic signed [X_W-1:0] X_ONE = 16'sh1000;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic                  op;
	logic signed [X_W-1:0] sample_x0;
	logic signed [X_W-1:0] sample_x1;
	logic                  target_class;
	logic                  last_sample;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  done;
	logic                  is_training_report;
	logic                  predicted_class;
	logic signed [W_W-1:0] weight_0;
	logic signed [W_W-1:0] weight_1;
	logic [EP_W-1:0]       epochs_run;
	logic                  train_status;

	int mismatches, pending, reports, capped, answers;
	int requests;

	perceptron_batch_trainer_unit dut (.*);

	perceptron_batch_trainer_checker chk (
		.*,
		.errors  (mismatches),
		.pending (pending),
		.reports (reports),
		.capped  (capped),
		.answers (answers)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop in case a result never shows up
	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end

	// drive one request and hold it until the unit takes it
	task automatic push_request(input opcode_t kind, input logic signed [X_W-1:0] a,
			input logic signed [X_W-1:0] b, input logic t, input logic l);
		start <= 1'b1;
		op <= kind;
		sample_x0 <= a;
		sample_x1 <= b;
		target_class <= t;
		last_sample <= l;
		do @(posedge clk); while (busy);
		requests++;
	endtask

	// drop start for a random gap, mostly short, now and then long
	task automatic pause();
		int r;
		int gap;
		r = $urandom_range(0, 99);
		if (r < 55)
			gap = 0;
		else if (r < 88)
			gap = $urandom_range(1, 3);
		else if (r < 97)
			gap = $urandom_range(4, 12);
		else
			gap = $urandom_range(20, 60);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold off until every predicted result has come and the unit is idle
	task automatic wait_quiet();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0 || busy);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// write all four registers back to back once the unit is quiet
	task automatic set_regs(input logic [LR_W-1:0] lr, input logic [CFG_DATA_W-1:0] thr_v,
			input logic [EP_W-1:0] ep, input logic [TOL_W-1:0] tol);
		wait_quiet();
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_LEARNING_RATE;
		cfg_wdata <= CFG_DATA_W'(lr);
		@(posedge clk);
		cfg_index <= CFG_THRESHOLD;
		cfg_wdata <= thr_v;
		@(posedge clk);
		cfg_index <= CFG_MAX_EPOCHS;
		cfg_wdata <= CFG_DATA_W'(ep);
		@(posedge clk);
		cfg_index <= CFG_TOLERANCE;
		cfg_wdata <= CFG_DATA_W'(tol);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic signed [X_W-1:0] pick_x();
		case ($urandom_range(0, 7))
			0:       return X_MIN;
			1:       return X_MAX;
			2:       return '0;
			3, 4:    return X_W'($urandom_range(0, 16383) - 8192);
			default: return X_W'($urandom);
		endcase
	endfunction

	initial begin
		logic [LR_W-1:0]       lr;
		logic [CFG_DATA_W-1:0] thr_v;
		logic [EP_W-1:0]       ep;
		logic [TOL_W-1:0]      tol;
		logic signed [X_W-1:0] a, b;
		int                    len, quota;
		bit                    roomy, calm, lean;

		start <= 1'b0;
		op <= OP_LOAD;
		sample_x0 <= '0;
		sample_x1 <= '0;
		target_class <= 1'b0;
		last_sample <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= CFG_LEARNING_RATE;
		cfg_wdata <= '0;
		arst_n <= 1'b0;
		requests = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: classify with zero weights, then two easy batches
		push_request(OP_CLASSIFY, '0, '0, 1'b1, 1'b1);
		pause();
		push_request(OP_CLASSIFY, X_MIN, X_MAX, 1'b0, 1'b0);
		push_request(OP_LOAD, X_ONE, X_ONE, 1'b1, 1'b1);
		pause();
		push_request(OP_LOAD, X_ONE, '0, 1'b1, 1'b0);
		push_request(OP_LOAD, -X_ONE, '0, 1'b0, 1'b1);
		push_request(OP_CLASSIFY, -X_ONE, X_ONE, 1'b0, 1'b0);

		// no epochs allowed: weights stay zero, cap reported
		set_regs(12'd4095, 32'h7fff_ffff, 16'd0, 12'd0);
		push_request(OP_LOAD, X_MIN, X_MAX, 1'b1, 1'b1);
		push_request(OP_CLASSIFY, X_MAX, X_MIN, 1'b1, 1'b0);

		// conflicting labels never settle: hit the epoch cap
		set_regs(12'd410, '0, 16'd3, 12'd0);
		push_request(OP_LOAD, X_ONE, '0, 1'b0, 1'b0);
		pause();
		push_request(OP_LOAD, X_ONE, '0, 1'b1, 1'b1);
		push_request(OP_CLASSIFY, X_ONE, '0, 1'b0, 1'b1);

		// largest cap and tolerance with a sample that is already right
		set_regs(12'd4095, 32'h7fff_ffff, 16'hffff, 12'd4095);
		push_request(OP_LOAD, X_MIN, X_MAX, 1'b0, 1'b1);
		push_request(OP_CLASSIFY, X_MAX, X_MAX, 1'b0, 1'b0);

		// zero rate and lowest threshold: mistakes move nothing
		set_regs(12'd0, 32'h8000_0000, 16'd1, 12'd0);
		push_request(OP_LOAD, X_MAX, X_MAX, 1'b0, 1'b0);
		push_request(OP_LOAD, X_MIN, X_MIN, 1'b0, 1'b1);
		push_request(OP_CLASSIFY, X_MIN, X_MIN, 1'b1, 1'b1);

		// random phases, each with its own settings
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			roomy = ($urandom_range(0, 2) == 0);
			calm = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 5))
				0:       lr = '0;
				1:       lr = 12'd4095;
				default: lr = LR_W'($urandom_range(1, 4095));
			endcase
			case ($urandom_range(0, 5))
				0:       thr_v = 32'h7fff_ffff;
				1:       thr_v = 32'h8000_0000;
				2:       thr_v = '0;
				3:       thr_v = $urandom;
				default: thr_v = $urandom_range(0, 131071) - 65536;
			endcase
			if (roomy)
				ep = EP_W'($urandom_range(1, 8));
			else if ($urandom_range(0, 4) == 0)
				ep = 16'd1;
			else
				ep = EP_W'($urandom_range(2, 40));
			case ($urandom_range(0, 4))
				0:       tol = '0;
				1:       tol = 12'd4095;
				default: tol = TOL_W'($urandom_range(0, 600));
			endcase
			// one phase with the top cap; zero rate keeps it to one epoch
			if (ph == 1) begin
				lr = '0;
				ep = 16'hffff;
			end
			set_regs(lr, thr_v, ep, tol);

			quota = requests + REQUEST_GOAL / RANDOM_PHASES;
			while (requests < quota) begin
				// mostly small batches, a few that overflow the store
				if (roomy && $urandom_range(0, 5) == 0)
					len = $urandom_range(MAX_SAMPLES - 4, MAX_SAMPLES + 6);
				else
					len = $urandom_range(1, 8);
				lean = ($urandom_range(0, 3) != 0);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 4) == 0) begin
						push_request(OP_CLASSIFY, pick_x(), pick_x(),
							1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
						if (!calm)
							pause();
					end
					a = pick_x();
					b = pick_x();
					push_request(OP_LOAD, a, b,
						lean ? (a + b >= 0) : 1'($urandom_range(0, 1)), i == len - 1);
					if (!calm)
						pause();
				end
				if ($urandom_range(0, 15) == 0)
					wait_quiet();
			end
		end

		wait_quiet();
		$display("Summary: %0d requests, %0d training reports (%0d at the epoch cap), %0d classifications",
			requests, reports, capped, answers);
		if (mismatches == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
